[hdl/mlfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants for the length-prefixed frame deframer: sync
// bytes, register reset value, phase encoding and the result record.
// ----------------------------------------------------------------------------
package mlfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hA5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h5A;

	// header is two sync bytes and two length bytes
	localparam int unsigned HEADER_LEN = 4;

	localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 16'd256;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SEEN_FIRST,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              last;
		logic [LEN_W-1:0]  frame_length;
	} result_t;

endpackage

[hdl/mlfd_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_in_reg
// Input register: captures one received byte per request and holds it until
// the deframer core consumes it.
// ----------------------------------------------------------------------------
module mlfd_in_reg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mlfd_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         rx_valid,
	output logic                         rx_ready,
	input  logic                         take,
	output logic                         valid_s1,
	output logic [mlfd_pkg::BYTE_W-1:0]  byte_s1
);
	import mlfd_pkg::*;

	// ready when empty or when the held byte leaves this cycle
	assign rx_ready = !valid_s1 || take;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

[hdl/mlfd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_core
// Sync hunt and header parse state machine. Steps once per consumed byte and
// produces a payload result while in the payload phase.
// ----------------------------------------------------------------------------
module mlfd_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [mlfd_pkg::BYTE_W-1:0]  byte_in,
	input  logic [mlfd_pkg::LEN_W-1:0]   max_payload,
	output logic                         produces,
	output mlfd_pkg::result_t            result
);
	import mlfd_pkg::*;

	phase_t              phase_q, phase_d;
	logic [BYTE_W-1:0]   len_lo_q, len_lo_d;
	logic [LEN_W-1:0]    len_q, len_d;
	logic [LEN_W-1:0]    rem_q, rem_d;
	logic [LEN_W-1:0]    hdr_len;
	logic                hdr_bad;
	phase_t              after_byte;

	// header length from stored low byte and current high byte
	assign hdr_len    = {byte_in, len_lo_q};
	assign hdr_bad    = (hdr_len == '0) || (hdr_len > max_payload);
	assign after_byte = (byte_in == SYNC_FIRST) ? PH_SEEN_FIRST : PH_HUNT;

	// next state
	always_comb begin
		phase_d  = phase_q;
		len_lo_d = len_lo_q;
		len_d    = len_q;
		rem_d    = rem_q;
		unique case (phase_q)
			PH_SEEN_FIRST: begin
				phase_d = (byte_in == SYNC_SECOND) ? PH_LEN_LO : after_byte;
			end
			PH_LEN_LO: begin
				len_lo_d = byte_in;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				if (hdr_bad) begin
					// drop first sync byte, rescan the length bytes
					if (len_lo_q == SYNC_FIRST && byte_in == SYNC_SECOND) begin
						phase_d = PH_LEN_LO;
					end else begin
						phase_d = after_byte;
					end
				end else begin
					len_d   = hdr_len;
					rem_d   = hdr_len;
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				rem_d = rem_q - LEN_W'(1);
				if (rem_q == LEN_W'(1)) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = after_byte;
			end
		endcase
	end

	// outputs
	always_comb begin
		produces            = (phase_q == PH_PAYLOAD);
		result.payload_byte = byte_in;
		result.last         = (rem_q == LEN_W'(1));
		result.frame_length = len_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			len_lo_q <= '0;
			len_q    <= '0;
			rem_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			rem_q    <= rem_d;
		end
	end

	// payload phase always has bytes left to deliver
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q != '0))
		else $error("payload phase with no bytes remaining");

	// remaining count never exceeds the announced length
	a_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (rem_q <= len_q))
		else $error("remaining count above frame length");

	// final payload byte returns the machine to hunting
	a_last_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(step && produces && result.last) |=> (phase_q == PH_HUNT))
		else $error("frame end did not return to hunt");

	// an accepted header respects the limit in force
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_LEN_HI && !hdr_bad) |->
		(hdr_len != '0 && hdr_len <= max_payload))
		else $error("header accepted outside length limit");

endmodule

[hdl/mlfd_out_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfd_out_reg
// Result register: holds one payload result until the downstream side takes
// it, and reports when a new result can be loaded.
// ----------------------------------------------------------------------------
module mlfd_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  mlfd_pkg::result_t    load_data,
	output logic                 free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mlfd_pkg::result_t    out_data
);
	import mlfd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// slot is free when empty or draining this cycle
	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result capture
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

[hdl/magic_length_frame_deframer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magic_length_frame_deframer
// Byte-stream deframer: hunts for sync pair A5 5A, reads a little-endian
// 16-bit length and forwards the payload bytes with a last marker.
// ----------------------------------------------------------------------------
// Takes one received byte per request and sustains one byte per clock with
// both sides streaming. A byte is held in an input register while the
// sync/header state machine acts on it, and payload bytes pass from there
// into a result register, from which they are offered at the output.
// Header and sync bytes produce no result and never stall; a payload byte
// waits only while the result register is full and not draining. A header
// whose length is zero or above max_payload is dropped silently and the
// length bytes are rescanned for a new sync pair. max_payload resets to 256
// and should be written only while no frame is in flight.
module magic_length_frame_deframer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mlfd_pkg::BYTE_W-1:0]  rx_byte,
	input  logic                         rx_valid,
	output logic                         rx_ready,
	output logic [mlfd_pkg::BYTE_W-1:0]  payload_byte,
	output logic                         last,
	output logic [mlfd_pkg::LEN_W-1:0]   frame_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         cfg_we,
	input  logic [mlfd_pkg::LEN_W-1:0]   cfg_wdata
);
	import mlfd_pkg::*;

	logic               valid_s1;
	logic [BYTE_W-1:0]  byte_s1;
	logic               take;
	logic               produces;
	logic               slot_free;
	logic [LEN_W-1:0]   max_payload_q;
	result_t            core_result;
	result_t            out_data;

	// max payload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// the held byte advances unless its result has nowhere to go
	assign take = valid_s1 && (!produces || slot_free);

	mlfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mlfd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (take),
		.byte_in     (byte_s1),
		.max_payload (max_payload_q),
		.produces    (produces),
		.result      (core_result)
	);

	mlfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && produces),
		.load_data (core_result),
		.free      (slot_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// result fields
	assign payload_byte = out_data.payload_byte;
	assign last         = out_data.last;
	assign frame_length = out_data.frame_length;

endmodule
